@@ rtl/core/gn3d_pkg.sv @@
`default_nettype none

package gn3d_pkg;

	localparam int DEF_COORD_FRAC_BITS = 16;
	localparam int DEF_OUT_FRAC_BITS   = 14;

	localparam int COORD_W  = 32;
	localparam int NOISE_W  = 16;
	localparam int LAT_BITS = 8;

	localparam int NOISE_MAX = 32767;
	localparam int NOISE_MIN = -32768;

	// Number of register stages from input port to output register.
	localparam int NUM_STAGES = 13;

	localparam logic [LAT_BITS-1:0] PERM_ROM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
		8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
		8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
		8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
		8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
		8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
		8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
		8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
		8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
		8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
		8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
		8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
		8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
		8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
		8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
		8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
		8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
		8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
		8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
		8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
		8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
		8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
		8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
		8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
		8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
		8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
		8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
		8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
	};

endpackage

`default_nettype wire

@@ rtl/core/gradient_noise_3d.sv @@
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+------------------------------------
// input   | in        | in_valid / in_ready  | coord_x, coord_y, coord_z (s32)
// output  | out       | out_valid / out_ready| noise_value (s16)
//
// One beat can enter every cycle while in_ready is high. The fade multiplier chain
// (t*t, t2*t, t3*p) sets the depth ahead of the interpolation stages.
// Reset clears only the per-stage valid bits; payload registers are not reset.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and an output stall only blocks the input once every stage holds a beat.
`default_nettype none

module gradient_noise_3d #(
	parameter int COORD_FRAC_BITS = gn3d_pkg::DEF_COORD_FRAC_BITS,
	parameter int OUT_FRAC_BITS   = gn3d_pkg::DEF_OUT_FRAC_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [gn3d_pkg::COORD_W-1:0]  coord_x,
	input  wire logic signed [gn3d_pkg::COORD_W-1:0]  coord_y,
	input  wire logic signed [gn3d_pkg::COORD_W-1:0]  coord_z,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [gn3d_pkg::NOISE_W-1:0]       noise_value
);

	localparam int F   = COORD_FRAC_BITS;
	localparam int LB  = gn3d_pkg::LAT_BITS;
	localparam int NS  = gn3d_pkg::NUM_STAGES;
	localparam int GW  = F + 2;       // gradient and interpolated values
	localparam int DW  = F + 3;       // difference of two interpolated values
	localparam int PW  = 2 * F + 5;   // lerp product
	localparam int TTW = 2 * F;       // t*t and t2*t
	localparam int PNW = 2 * F + 4;   // fade polynomial numerator, t3*p
	localparam int PPW = F + 4;       // fade polynomial p
	localparam int UP  = (OUT_FRAC_BITS >= F) ? OUT_FRAC_BITS - F : 0;
	localparam int DN  = (F > OUT_FRAC_BITS) ? F - OUT_FRAC_BITS : 1;
	localparam int RW0 = F + 3 + UP;
	localparam int RW  = (RW0 > 18) ? RW0 : 18;

	localparam logic [PNW-1:0]        HALF_U = PNW'(2 ** (F - 1));
	localparam logic signed [PW-1:0]  HALF_P = PW'(2 ** (F - 1));
	localparam logic signed [GW-1:0]  ONE_G  = GW'(2 ** F);
	localparam logic signed [RW-1:0]  SAT_HI = RW'(gn3d_pkg::NOISE_MAX);
	localparam logic signed [RW-1:0]  SAT_LO = RW'(gn3d_pkg::NOISE_MIN);

	// Unsigned round half up of v / 2^F.
	function automatic logic [PNW-1:0] urnd(input logic [PNW-1:0] v);
		return (v + HALF_U) >> F;
	endfunction

	// 10*2^2F - 15*t*2^F + 6*t*t; intermediate wrap is harmless since the total is positive.
	function automatic logic [PNW-1:0] pn_calc(input logic [F-1:0] t,
		input logic [TTW-1:0] tt);
		logic [PNW-1:0] ten;
		logic [PNW-1:0] t15;
		logic [PNW-1:0] tt6;
		ten = PNW'(10) << (2 * F);
		t15 = ((PNW'(t) << 4) - PNW'(t)) << F;
		tt6 = (PNW'(tt) << 2) + (PNW'(tt) << 1);
		return ten - t15 + tt6;
	endfunction

	function automatic logic signed [GW-1:0] gcoord(input logic [F-1:0] t, input logic hi);
		logic signed [GW-1:0] s;
		s = signed'({2'b00, t});
		return hi ? s - ONE_G : s;
	endfunction

	function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
		input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
		input logic signed [GW-1:0] z);
		logic signed [GW-1:0] g;
		case (h)
			4'd0:    g =  x + y;
			4'd1:    g = -x + y;
			4'd2:    g =  x - y;
			4'd3:    g = -x - y;
			4'd4:    g =  x + z;
			4'd5:    g = -x + z;
			4'd6:    g =  x - z;
			4'd7:    g = -x - z;
			4'd8:    g =  y + z;
			4'd9:    g = -y + z;
			4'd10:   g =  y - z;
			4'd11:   g = -y - z;
			4'd12:   g =  y + x;
			4'd13:   g = -y + z;
			4'd14:   g =  y - x;
			default: g = -y - z;
		endcase
		return g;
	endfunction

	function automatic logic signed [PW-1:0] lerp_mul(input logic signed [GW-1:0] lo,
		input logic signed [GW-1:0] hi, input logic [F:0] w);
		logic signed [DW-1:0]  d;
		logic signed [F+1:0]   ws;
		d  = DW'(hi) - DW'(lo);
		ws = signed'({1'b0, w});
		return d * ws;
	endfunction

	function automatic logic signed [GW-1:0] lerp_fin(input logic signed [GW-1:0] lo,
		input logic signed [PW-1:0] prod);
		logic signed [PW-1:0] s;
		s = (prod + HALF_P) >>> F;
		return lo + GW'(s);
	endfunction

	// Handshake: per-stage load enables ripple back from the output.
	logic [NS:1] vld_q;
	logic [NS:1] en;
	logic        in_fire;
	logic        out_fire;

	always_comb begin
		en[NS] = !vld_q[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: split coordinates, first hash level, t*t.
	logic [LB-1:0]  cell_x;
	logic [LB-1:0]  cell_y;
	logic [LB-1:0]  cell_z;
	logic [F-1:0]   frac_in [3];

	assign cell_x     = coord_x[F+LB-1:F];
	assign cell_y     = coord_y[F+LB-1:F];
	assign cell_z     = coord_z[F+LB-1:F];
	assign frac_in[0] = coord_x[F-1:0];
	assign frac_in[1] = coord_y[F-1:0];
	assign frac_in[2] = coord_z[F-1:0];

	logic [LB-1:0]   a_s1 [2];
	logic [LB-1:0]   yc_s1;
	logic [LB-1:0]   zc_s1;
	logic [F-1:0]    t_s1 [3];
	logic [TTW-1:0]  tt_s1 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s1[0] <= gn3d_pkg::PERM_ROM[cell_x];
			a_s1[1] <= gn3d_pkg::PERM_ROM[LB'(cell_x + LB'(1))];
			yc_s1   <= cell_y;
			zc_s1   <= cell_z;
			for (int i = 0; i < 3; i++) begin
				t_s1[i]  <= frac_in[i];
				tt_s1[i] <= frac_in[i] * frac_in[i];
			end
		end
	end

	// Stage 2: second hash level, t2 and the fade polynomial numerator.
	logic [LB-1:0]   b_s2 [4];
	logic [LB-1:0]   zc_s2;
	logic [F-1:0]    t_s2 [3];
	logic [F-1:0]    t2_s2 [3];
	logic [PNW-1:0]  pn_s2 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 4; j++) begin
				b_s2[j] <= gn3d_pkg::PERM_ROM[LB'(a_s1[j[0]] + yc_s1 + LB'(j[1]))];
			end
			zc_s2 <= zc_s1;
			for (int i = 0; i < 3; i++) begin
				t_s2[i]  <= t_s1[i];
				t2_s2[i] <= F'(urnd(PNW'(tt_s1[i])));
				pn_s2[i] <= pn_calc(t_s1[i], tt_s1[i]);
			end
		end
	end

	// Stage 3: corner hashes, t2*t, p.
	// Corner index is x + 2*y + 4*z, each bit selecting the upper lattice neighbor.
	logic [LB-1:0]   h_s3 [8];
	logic [F-1:0]    t_s3 [3];
	logic [TTW-1:0]  t2t_s3 [3];
	logic [PPW-1:0]  p_s3 [3];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int c = 0; c < 8; c++) begin
				h_s3[c] <= gn3d_pkg::PERM_ROM[LB'(b_s2[c[1:0]] + zc_s2 + LB'(c[2]))];
			end
			for (int i = 0; i < 3; i++) begin
				t_s3[i]   <= t_s2[i];
				t2t_s3[i] <= t2_s2[i] * t_s2[i];
				p_s3[i]   <= PPW'(urnd(pn_s2[i]));
			end
		end
	end

	// Stage 4: gradient dot products, t3.
	logic signed [GW-1:0]  g_s4 [8];
	logic [F-1:0]          t3_s4 [3];
	logic [PPW-1:0]        p_s4 [3];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int c = 0; c < 8; c++) begin
				g_s4[c] <= grad(h_s3[c][3:0], gcoord(t_s3[0], c[0]),
					gcoord(t_s3[1], c[1]), gcoord(t_s3[2], c[2]));
			end
			for (int i = 0; i < 3; i++) begin
				t3_s4[i] <= F'(urnd(PNW'(t2t_s3[i])));
				p_s4[i]  <= p_s3[i];
			end
		end
	end

	// Stage 5: t3*p.
	logic signed [GW-1:0]  g_s5 [8];
	logic [PNW-1:0]        tp_s5 [3];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			g_s5 <= g_s4;
			for (int i = 0; i < 3; i++) begin
				tp_s5[i] <= t3_s4[i] * p_s4[i];
			end
		end
	end

	// Stage 6: fade weights.
	logic signed [GW-1:0]  g_s6 [8];
	logic [F:0]            fade_s6 [3];

	always_ff @(posedge clk) begin
		if (en[6]) begin
			g_s6 <= g_s5;
			for (int i = 0; i < 3; i++) begin
				fade_s6[i] <= (F + 1)'(urnd(tp_s5[i]));
			end
		end
	end

	// Stages 7 and 8: interpolate along x.
	logic signed [PW-1:0]  prod_s7 [4];
	logic signed [GW-1:0]  lo_s7 [4];
	logic [F:0]            v_s7;
	logic [F:0]            w_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int k = 0; k < 4; k++) begin
				prod_s7[k] <= lerp_mul(g_s6[2*k], g_s6[2*k+1], fade_s6[0]);
				lo_s7[k]   <= g_s6[2*k];
			end
			v_s7 <= fade_s6[1];
			w_s7 <= fade_s6[2];
		end
	end

	logic signed [GW-1:0]  x_s8 [4];
	logic [F:0]            v_s8;
	logic [F:0]            w_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int k = 0; k < 4; k++) begin
				x_s8[k] <= lerp_fin(lo_s7[k], prod_s7[k]);
			end
			v_s8 <= v_s7;
			w_s8 <= w_s7;
		end
	end

	// Stages 9 and 10: interpolate along y.
	logic signed [PW-1:0]  prod_s9 [2];
	logic signed [GW-1:0]  lo_s9 [2];
	logic [F:0]            w_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int k = 0; k < 2; k++) begin
				prod_s9[k] <= lerp_mul(x_s8[2*k], x_s8[2*k+1], v_s8);
				lo_s9[k]   <= x_s8[2*k];
			end
			w_s9 <= w_s8;
		end
	end

	logic signed [GW-1:0]  y_s10 [2];
	logic [F:0]            w_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			for (int k = 0; k < 2; k++) begin
				y_s10[k] <= lerp_fin(lo_s9[k], prod_s9[k]);
			end
			w_s10 <= w_s9;
		end
	end

	// Stages 11 and 12: interpolate along z.
	logic signed [PW-1:0]  prod_s11;
	logic signed [GW-1:0]  lo_s11;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			prod_s11 <= lerp_mul(y_s10[0], y_s10[1], w_s10);
			lo_s11   <= y_s10[0];
		end
	end

	logic signed [GW-1:0]  r_s12;

	always_ff @(posedge clk) begin
		if (en[12]) begin
			r_s12 <= lerp_fin(lo_s11, prod_s11);
		end
	end

	// Stage 13: rescale to the output format and saturate.
	logic signed [RW-1:0]                    scaled;
	logic signed [gn3d_pkg::NOISE_W-1:0]     noise_d;
	logic signed [gn3d_pkg::NOISE_W-1:0]     noise_s13;

	if (OUT_FRAC_BITS >= COORD_FRAC_BITS) begin : g_up
		assign scaled = RW'(r_s12) <<< UP;
	end else begin : g_dn
		localparam logic signed [RW-1:0] RND = RW'(2 ** (DN - 1));
		assign scaled = (RW'(r_s12) + RND) >>> DN;
	end

	always_comb begin
		if (scaled > SAT_HI) begin
			noise_d = gn3d_pkg::NOISE_W'(SAT_HI);
		end else if (scaled < SAT_LO) begin
			noise_d = gn3d_pkg::NOISE_W'(SAT_LO);
		end else begin
			noise_d = gn3d_pkg::NOISE_W'(scaled);
		end
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			noise_s13 <= noise_d;
		end
	end

	assign noise_value = noise_s13;

	// An output that is being taken frees every stage behind it.
	assert property (@(posedge clk) disable iff (!arst_n) out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// The input only stalls when the pipeline is full and the output is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled with room in the pipeline");

	// Beats in flight change only by accepted input and delivered output.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_q) + $past(out_fire)) ==
			($past($countones(vld_q)) + $past(in_fire)))
		else $error("beat lost or duplicated in pipeline");

endmodule

`default_nettype wire
